>>> sv/fwdp_pkg.sv
// fwdp_pkg: shared constants and codes for the FIFO with duplicate purge.
// No dependencies; imported by fifo_with_duplicate_purge_top and tb.
`default_nettype none
package fwdp_pkg;

  localparam int unsigned FWDP_DEPTH = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_PURGE   = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic [VALUE_W-1:0] EMPTY_DATA = '1;

endpackage
`default_nettype wire

>>> sv/fifo_with_duplicate_purge_top.sv
// FIFO of 32-bit values over a synchronous store with one write and one read port, with a duplicate purge.
// Depends on fwdp_pkg (widths, action and status codes).
//
// Usage:
//   Input stream: s_axis_tuser_i carries the action (enqueue, dequeue, purge),
//   s_axis_tdata_i the value to enqueue. Each input word gives one output word:
//   tdata = {occupancy, data}, tuser = status.
//   Enqueue, unused codes and an empty dequeue or purge answer straight from
//   the output register; a dequeue first passes the store read register and
//   S_DEQ_WAIT. A purge walks the held entries: per entry one read, then one
//   read and one compare per kept entry checked, plus a write for a survivor.
//   s_axis_tready_o is low while it runs.
//   Enqueues can follow back to back; a dequeue holds s_axis_tready_o low
//   until the single store read port fills the one-deep output register.
//   Reset clears head, tail and count; the store itself is not cleared and
//   never needs to be, since only held entries are read.
//   A stalled receiver holds the output word; a new input word is taken only
//   once the output register is empty or being emptied in that cycle.
`default_nettype none
module fifo_with_duplicate_purge_top #(
  parameter int unsigned DEPTH = fwdp_pkg::FWDP_DEPTH
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  // value[31:0]
  input  wire logic [fwdp_pkg::VALUE_W-1:0]              s_axis_tdata_i,
  // action[1:0]
  input  wire logic [fwdp_pkg::ACTION_W-1:0]             s_axis_tuser_i,
  input  wire logic                                      s_axis_tvalid_i,
  output logic                                           s_axis_tready_o,
  // data[31:0], occupancy[36:32] at 16 entries, zero fill to bytes
  output logic [((fwdp_pkg::VALUE_W + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0]
                                                         m_axis_tdata_o,
  // status[1:0]
  output logic [fwdp_pkg::STATUS_W-1:0]                  m_axis_tuser_o,
  output logic                                           m_axis_tvalid_o,
  input  wire logic                                      m_axis_tready_i
);
  import fwdp_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned OUTW = ((VALUE_W + CW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ_WAIT,
    S_P_CAND,
    S_P_CAPT,
    S_P_SRD,
    S_P_SCMP,
    S_P_KEEP,
    S_P_FIN
  } state_e;

  function automatic logic [AW-1:0] pos_at(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rdata_q;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;

  state_e             state_q, state_d;
  logic [AW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      i_q, i_d, j_q, j_d, kept_q, kept_d;
  logic [VALUE_W-1:0] cand_q, cand_d;
  logic               ovalid_q, ovalid_d;
  logic [VALUE_W-1:0] odata_q, odata_d;
  status_e            ostat_q, ostat_d;
  logic [CW-1:0]      oocc_q, oocc_d;

  logic               in_acc;
  logic               out_acc;
  action_e            act;
  logic [CW-1:0]      i_next;

  assign out_acc         = ovalid_q & m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) & (~ovalid_q | m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign act             = action_e'(s_axis_tuser_i);
  assign i_next          = i_q + CW'(1);

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = OUTW'({oocc_q, odata_q});
  assign m_axis_tuser_o  = ostat_q;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    i_d      = i_q;
    j_d      = j_q;
    kept_d   = kept_q;
    cand_d   = cand_q;
    ovalid_d = out_acc ? 1'b0 : ovalid_q;
    odata_d  = odata_q;
    ostat_d  = ostat_q;
    oocc_d   = oocc_q;
    raddr    = head_q;
    we       = 1'b0;
    waddr    = tail_q;
    wdata    = s_axis_tdata_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          odata_d = '0;
          ostat_d = ST_OK;
          unique case (act)
            ACT_ENQUEUE: begin
              ovalid_d = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                ostat_d = ST_FULL;
                oocc_d  = count_q;
              end else begin
                we      = 1'b1;
                tail_d  = pos_at(tail_q, CW'(1));
                count_d = count_q + CW'(1);
                oocc_d  = count_q + CW'(1);
              end
            end
            ACT_DEQUEUE: begin
              if (count_q == '0) begin
                ovalid_d = 1'b1;
                odata_d  = EMPTY_DATA;
                ostat_d  = ST_EMPTY;
                oocc_d   = count_q;
              end else begin
                head_d  = pos_at(head_q, CW'(1));
                count_d = count_q - CW'(1);
                state_d = S_DEQ_WAIT;
              end
            end
            ACT_PURGE: begin
              if (count_q == '0) begin
                ovalid_d = 1'b1;
                oocc_d   = count_q;
              end else begin
                i_d     = '0;
                kept_d  = '0;
                state_d = S_P_CAND;
              end
            end
            default: begin
              ovalid_d = 1'b1;
              oocc_d   = count_q;
            end
          endcase
        end
      end
      S_DEQ_WAIT: begin
        ovalid_d = 1'b1;
        odata_d  = rdata_q;
        ostat_d  = ST_OK;
        oocc_d   = count_q;
        state_d  = S_IDLE;
      end
      S_P_CAND: begin
        raddr   = pos_at(head_q, i_q);
        state_d = S_P_CAPT;
      end
      S_P_CAPT: begin
        cand_d = rdata_q;
        j_d    = '0;
        if (kept_q == '0) state_d = S_P_KEEP;
        else state_d = S_P_SRD;
      end
      S_P_SRD: begin
        raddr   = pos_at(head_q, j_q);
        state_d = S_P_SCMP;
      end
      S_P_SCMP: begin
        if (rdata_q == cand_q) begin
          i_d     = i_next;
          state_d = (i_next == count_q) ? S_P_FIN : S_P_CAND;
        end else if (j_q + CW'(1) == kept_q) begin
          state_d = S_P_KEEP;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_P_SRD;
        end
      end
      S_P_KEEP: begin
        we      = 1'b1;
        waddr   = pos_at(head_q, kept_q);
        wdata   = cand_q;
        kept_d  = kept_q + CW'(1);
        i_d     = i_next;
        state_d = (i_next == count_q) ? S_P_FIN : S_P_CAND;
      end
      S_P_FIN: begin
        count_d  = kept_q;
        tail_d   = pos_at(head_q, kept_q);
        ovalid_d = 1'b1;
        odata_d  = '0;
        ostat_d  = ST_OK;
        oocc_d   = kept_q;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      i_q      <= '0;
      j_q      <= '0;
      kept_q   <= '0;
      cand_q   <= '0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
      ostat_q  <= ST_OK;
      oocc_q   <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      i_q      <= i_d;
      j_q      <= j_d;
      kept_q   <= kept_d;
      cand_q   <= cand_d;
      ovalid_q <= ovalid_d;
      odata_q  <= odata_d;
      ostat_q  <= ostat_d;
      oocc_q   <= oocc_d;
    end
  end

  // entry store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
// tb: self-checking bench for fifo_with_duplicate_purge_top over its stream ports.
// Depends on fwdp_pkg and the top module; a directed table, then random words,
// checked against table values or a queue-based predictor of FIFO and purge.
`default_nettype none
module tb;
  import fwdp_pkg::*;

  localparam int unsigned OCC_W        = $clog2(FWDP_DEPTH + 1);
  localparam int unsigned TDATA_W      = ((VALUE_W + OCC_W + 7) / 8) * 8;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 1950;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    status_e            status;
    logic [OCC_W-1:0]   occ;
  } fifo_word_t;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
    bit                  typed;
    fifo_word_t          want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic [VALUE_W-1:0]  s_axis_tdata_i;
  logic [ACTION_W-1:0] s_axis_tuser_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [TDATA_W-1:0]  m_axis_tdata_o;
  logic [STATUS_W-1:0] m_axis_tuser_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;

  logic [VALUE_W-1:0] queue_model[$];
  fifo_word_t         due_words[$];
  stim_row_t          stim_table[$];
  int                 mismatches = 0;

  fifo_with_duplicate_purge_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic fifo_word_t predict_fifo_step(input logic [ACTION_W-1:0] action,
                                                   input logic [VALUE_W-1:0] value);
    fifo_word_t         res;
    logic [VALUE_W-1:0] kept[$];
    bit                 dup;
    res.data   = '0;
    res.status = ST_OK;
    case (action)
      ACT_ENQUEUE: begin
        if (queue_model.size() >= FWDP_DEPTH) res.status = ST_FULL;
        else queue_model.push_back(value);
      end
      ACT_DEQUEUE: begin
        if (queue_model.size() == 0) begin
          res.data   = EMPTY_DATA;
          res.status = ST_EMPTY;
        end else begin
          res.data = queue_model.pop_front();
        end
      end
      ACT_PURGE: begin
        // keep first occurrence of each value, original order
        foreach (queue_model[i]) begin
          dup = 1'b0;
          foreach (kept[j]) if (kept[j] == queue_model[i]) dup = 1'b1;
          if (!dup) kept.push_back(queue_model[i]);
        end
        queue_model = kept;
      end
      default: ;
    endcase
    res.occ = OCC_W'(queue_model.size());
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_row(input logic [ACTION_W-1:0] action,
                                  input logic [VALUE_W-1:0] value,
                                  input bit typed, input fifo_word_t want);
    stim_row_t row;
    row.action = action;
    row.value  = value;
    row.typed  = typed;
    row.want   = want;
    stim_table.push_back(row);
  endfunction

  task automatic send_word(input logic [ACTION_W-1:0] action, input logic [VALUE_W-1:0] value,
                           input bit typed, input fifo_word_t want, input int gap);
    fifo_word_t pred;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= action;
    s_axis_tdata_i  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_fifo_step(action, value);
    due_words.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (due_words.size() != 0);
  endtask

  // receiver backpressure
  initial begin
    int stall_left;
    int cyc;
    bit rx_steady;
    stall_left = 0;
    cyc        = 0;
    rx_steady  = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 250 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    fifo_word_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, got data %h status %0d occupancy %0d", $time,
                 m_axis_tdata_o[VALUE_W-1:0], m_axis_tuser_o,
                 m_axis_tdata_o[VALUE_W +: OCC_W]);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        if (m_axis_tdata_o[VALUE_W-1:0] !== want.data) begin
          $display("%0t: data expected %h got %h", $time, want.data,
                   m_axis_tdata_o[VALUE_W-1:0]);
          mismatches++;
        end
        if (m_axis_tuser_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tdata_o[VALUE_W +: OCC_W] !== want.occ) begin
          $display("%0t: occupancy expected %0d got %0d", $time, want.occ,
                   m_axis_tdata_o[VALUE_W +: OCC_W]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int                  counted;
    int                  r;
    bit                  tx_steady;
    bit                  filling;
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tuser_i  <= ACT_ENQUEUE;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b0;

    // empty cases, extremes, duplicates, fill to full, then purge and dequeue
    add_row(ACT_DEQUEUE, '0, 1'b1, fifo_word_t'{EMPTY_DATA, ST_EMPTY, 5'd0});
    add_row(ACT_PURGE, '0, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd0});
    add_row(ACT_UNUSED, '1, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd0});
    add_row(ACT_ENQUEUE, 32'h8000_0000, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd1});
    add_row(ACT_ENQUEUE, 32'h7fff_ffff, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd2});
    add_row(ACT_ENQUEUE, 32'h0000_0000, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd3});
    add_row(ACT_ENQUEUE, 32'hffff_ffff, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd4});
    add_row(ACT_ENQUEUE, 32'h8000_0000, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd5});
    add_row(ACT_ENQUEUE, 32'h7fff_ffff, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd6});
    add_row(ACT_PURGE, '0, 1'b1, fifo_word_t'{32'd0, ST_OK, 5'd4});
    add_row(ACT_DEQUEUE, '0, 1'b1, fifo_word_t'{32'h8000_0000, ST_OK, 5'd3});
    for (int i = 0; i < 13; i++) add_row(ACT_ENQUEUE, 32'h5a5a_0000 + (i % 4), 1'b0, '0);
    add_row(ACT_ENQUEUE, 32'h1234_5678, 1'b1, fifo_word_t'{32'd0, ST_FULL, 5'd16});
    add_row(ACT_PURGE, '0, 1'b0, '0);
    add_row(ACT_DEQUEUE, '0, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i])
      send_word(stim_table[i].action, stim_table[i].value, stim_table[i].typed,
                stim_table[i].want, idle_len());
    drain_results();

    counted   = 0;
    tx_steady = 1'b0;
    while (counted < RANDOM_WORDS) begin
      if (counted % 100 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      // alternate phases that fill and drain the store
      filling = ((counted / 150) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < (filling ? 60 : 30)) act = ACT_ENQUEUE;
      else if (r < 82) act = ACT_DEQUEUE;
      else if (r < 96) act = ACT_PURGE;
      else act = ACT_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 50) val = $urandom_range(0, 5);
      else if (r < 55) val = 32'h8000_0000;
      else if (r < 60) val = 32'h7fff_ffff;
      else if (r < 65) val = '1;
      else val = $urandom;
      send_word(act, val, 1'b0, '0, tx_steady ? 0 : idle_len());
      counted++;
      if (counted % 500 == 0) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> fifo_with_duplicate_purge_top.f
sv/fwdp_pkg.sv
sv/fifo_with_duplicate_purge_top.sv
bench/tb.sv
